// File: rtl/core/bwts_pkg.sv
package bwts_pkg;

    // Candidate thresholds and field widths.
    localparam int NUM_THR   = 13;
    localparam int RGB_W     = 8;
    localparam int PSUM_W    = 10;
    localparam int CNT_W     = 18;
    localparam int SUM_W     = CNT_W + 1;
    localparam int IDX_W     = $clog2(NUM_THR);
    localparam int THR_W     = 8;
    localparam int DIM_W     = 11;
    localparam int AREA_W    = 2 * DIM_W;
    localparam int BOUND_W   = AREA_W - 2;
    localparam int CFG_IDX_W = 8;

    localparam logic [CNT_W-1:0] CNT_LIMIT   = '1;
    localparam logic [THR_W-1:0] THR_FIRST   = 8'd32;
    localparam logic [THR_W-1:0] THR_STEP    = 8'd16;
    localparam logic [THR_W-1:0] THR_DEFAULT = 8'd128;
    localparam logic [IDX_W-1:0] IDX_DEFAULT = IDX_W'((THR_DEFAULT - THR_FIRST) / THR_STEP);

    // Per-threshold group flags.
    localparam logic [1:0] FLAG_CLEAR = 2'b01;
    localparam logic [1:0] FLAG_SET   = 2'b10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

    typedef logic [NUM_THR-1:0][CNT_W-1:0] t_cnt_vec;

    // One candidate in the selection tree.
    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] clr_cnt;
        logic [CNT_W-1:0] set_cnt;
    } t_cand;

    typedef struct packed {
        logic [CNT_W-1:0] clr_cnt;
        logic [CNT_W-1:0] set_cnt;
    } t_pair;

    // Threshold value for a candidate index.
    function automatic logic [THR_W-1:0] thr_of(logic [IDX_W-1:0] idx);
        return THR_FIRST + THR_STEP * THR_W'(idx);
    endfunction

    // Component sum at or above which a pixel is set.
    function automatic logic [PSUM_W-1:0] level_of(logic [IDX_W-1:0] idx);
        return PSUM_W'(3) * PSUM_W'(thr_of(idx));
    endfunction

    // Keep the lower-index candidate unless the other one is strictly smaller.
    function automatic t_cand pick(t_cand a, t_cand b);
        return (b.total < a.total) ? b : a;
    endfunction

endpackage

// File: rtl/core/bw_threshold_selector_core.sv
// Channel   Handshake                  Payload
// pixel in  i_in_valid / o_in_ready    i_red, i_green, i_blue, i_group_end, i_image_end
// result    o_out_valid / i_out_ready  o_chosen_threshold, o_clear_groups, o_set_groups,
//                                      o_used_default
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel is taken every cycle while the input is not stalled; all 13 threshold counters
// update in parallel from the input register. A pixel that ends the image passes through the
// input register, count snapshot, four stages of the minimum tree and the output register.
// Reset is synchronous and active low; it clears all counters and sets both dimensions to 1.
// A stalled result holds only image-end pixels behind it; up to seven finished images can
// wait in the pipeline before the input stalls.
module bw_threshold_selector_core
    import bwts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [RGB_W-1:0]     i_red,
    input  logic [RGB_W-1:0]     i_green,
    input  logic [RGB_W-1:0]     i_blue,
    input  logic                 i_group_end,
    input  logic                 i_image_end,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [THR_W-1:0]     o_chosen_threshold,
    output logic [CNT_W-1:0]     o_clear_groups,
    output logic [CNT_W-1:0]     o_set_groups,
    output logic                 o_used_default,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [BOUND_W-1:0] w_bound;
    logic               w_snap_valid;
    logic               w_snap_ready;
    t_cnt_vec           w_snap_clr;
    t_cnt_vec           w_snap_set;

    // Dimension registers and the initial bound.
    bwts_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_bound     (w_bound)
    );

    // Per-threshold group counting.
    bwts_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_group_end  (i_group_end),
        .i_image_end  (i_image_end),
        .o_snap_valid (w_snap_valid),
        .i_snap_ready (w_snap_ready),
        .o_snap_clr   (w_snap_clr),
        .o_snap_set   (w_snap_set)
    );

    // Threshold choice over the snapshot.
    bwts_select u_select (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_snap_valid       (w_snap_valid),
        .o_snap_ready       (w_snap_ready),
        .i_snap_clr         (w_snap_clr),
        .i_snap_set         (w_snap_set),
        .i_bound            (w_bound),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_chosen_threshold (o_chosen_threshold),
        .o_clear_groups     (o_clear_groups),
        .o_set_groups       (o_set_groups),
        .o_used_default     (o_used_default)
    );

`ifndef SYNTHESIS
    // The fallback always reports the default threshold.
    a_default_thr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_used_default |-> o_chosen_threshold == THR_DEFAULT)
        else $error("default result without the default threshold");

    // A chosen threshold is a grid value other than the default.
    a_chosen_thr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_used_default |->
            o_chosen_threshold[3:0] == 4'd0 && o_chosen_threshold >= THR_FIRST &&
            o_chosen_threshold <= 8'd224 && o_chosen_threshold != THR_DEFAULT)
        else $error("chosen threshold off the candidate grid");

    // A chosen threshold must have beaten the initial bound.
    a_under_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_used_default |->
            BOUND_W'(SUM_W'(o_clear_groups) + SUM_W'(o_set_groups)) < w_bound)
        else $error("chosen threshold does not beat the bound");
`endif

endmodule

// File: rtl/core/bwts_cfg.sv
module bwts_cfg
    import bwts_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic [BOUND_W-1:0]   o_bound
);

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [BOUND_W-1:0] r_bound;
    logic [AREA_W-1:0]  w_area;

    assign o_cfg_ready = 1'b1;
    assign o_bound     = r_bound;

    // The initial best bound is twice the number of whole groups in the image.
    assign w_area = AREA_W'(r_width) * AREA_W'(r_height);

    // Register writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_bound  <= '0;
        end else begin
            r_bound <= {w_area[AREA_W-1:3], 1'b0};
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: rtl/core/bwts_accum.sv
module bwts_accum
    import bwts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [RGB_W-1:0] i_red,
    input  logic [RGB_W-1:0] i_green,
    input  logic [RGB_W-1:0] i_blue,
    input  logic             i_group_end,
    input  logic             i_image_end,
    output logic             o_snap_valid,
    input  logic             i_snap_ready,
    output t_cnt_vec         o_snap_clr,
    output t_cnt_vec         o_snap_set
);

    logic                    r_a_valid;
    logic [RGB_W-1:0]        r_red;
    logic [RGB_W-1:0]        r_green;
    logic [RGB_W-1:0]        r_blue;
    logic                    r_gend;
    logic                    r_iend;
    logic [NUM_THR-1:0][1:0] r_flags;
    t_cnt_vec                r_clr;
    t_cnt_vec                r_set;

    logic [NUM_THR-1:0][1:0] n_flags;
    t_cnt_vec                n_clr;
    t_cnt_vec                n_set;
    logic [PSUM_W-1:0]       w_psum;
    logic                    w_close;
    logic                    w_fire;

    // A pixel that ends the image needs room in the snapshot stage; others always retire.
    assign w_fire       = r_a_valid && (!r_iend || i_snap_ready);
    assign o_in_ready   = !r_a_valid || w_fire;
    assign o_snap_valid = r_a_valid && r_iend;
    assign o_snap_clr   = n_clr;
    assign o_snap_set   = n_set;

    assign w_psum  = PSUM_W'(r_red) + PSUM_W'(r_green) + PSUM_W'(r_blue);
    assign w_close = r_gend || r_iend;

    // All thresholds update in parallel: flag update, then group count on a group or image end.
    always_comb begin
        logic [1:0] flag;
        for (int i = 0; i < NUM_THR; i++) begin
            if (w_psum >= level_of(IDX_W'(i))) begin
                flag = r_flags[i] & ~FLAG_CLEAR;
            end else begin
                flag = r_flags[i] & ~FLAG_SET;
            end
            n_clr[i]   = r_clr[i];
            n_set[i]   = r_set[i];
            n_flags[i] = flag;
            if (w_close) begin
                n_flags[i] = FLAG_CLEAR | FLAG_SET;
                if ((flag & FLAG_CLEAR) != 2'b00) begin
                    if (r_clr[i] != CNT_LIMIT) begin
                        n_clr[i] = r_clr[i] + CNT_W'(1);
                    end
                end else if ((flag & FLAG_SET) != 2'b00) begin
                    if (r_set[i] != CNT_LIMIT) begin
                        n_set[i] = r_set[i] + CNT_W'(1);
                    end
                end
            end
        end
    end

    // Input register control and the per-threshold state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_flags   <= {NUM_THR{FLAG_CLEAR | FLAG_SET}};
            r_clr     <= '0;
            r_set     <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (w_fire) begin
                if (r_iend) begin
                    r_flags <= {NUM_THR{FLAG_CLEAR | FLAG_SET}};
                    r_clr   <= '0;
                    r_set   <= '0;
                end else begin
                    r_flags <= n_flags;
                    r_clr   <= n_clr;
                    r_set   <= n_set;
                end
            end
        end
    end

    // Pixel payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_gend  <= i_group_end;
            r_iend  <= i_image_end;
        end
    end

endmodule

// File: rtl/core/bwts_select.sv
module bwts_select
    import bwts_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_snap_valid,
    output logic               o_snap_ready,
    input  t_cnt_vec           i_snap_clr,
    input  t_cnt_vec           i_snap_set,
    input  logic [BOUND_W-1:0] i_bound,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [THR_W-1:0]   o_chosen_threshold,
    output logic [CNT_W-1:0]   o_clear_groups,
    output logic [CNT_W-1:0]   o_set_groups,
    output logic               o_used_default
);

    localparam int L1 = (NUM_THR + 1) / 2;
    localparam int L2 = (L1 + 1) / 2;
    localparam int L3 = (L2 + 1) / 2;

    // Snapshot stage.
    logic     r_b_valid;
    t_cnt_vec r_b_clr;
    t_cnt_vec r_b_set;

    // Tree stages, each with the default candidate's counts alongside.
    logic  r1_valid, r2_valid, r3_valid, r4_valid;
    t_cand r1 [L1];
    t_cand r2 [L2];
    t_cand r3 [L3];
    t_cand r4;
    t_pair r1_def, r2_def, r3_def, r4_def;

    t_cand n1 [L1];
    t_cand n2 [L2];
    t_cand n3 [L3];
    t_cand n4;
    t_cand w_leaf [NUM_THR];
    t_pair w_def;

    logic             r_o_valid;
    logic [THR_W-1:0] r_o_thr;
    logic [CNT_W-1:0] r_o_clr;
    logic [CNT_W-1:0] r_o_set;
    logic             r_o_dflt;

    logic             adv_o, adv4, adv3, adv2, adv1, adv_b;
    logic             w_found;
    logic             w_take;
    logic [SUM_W-1:0] w_def_total;

    // Each stage moves when it is empty or the next one moves.
    assign adv_o        = !r_o_valid || i_out_ready;
    assign adv4         = !r4_valid || adv_o;
    assign adv3         = !r3_valid || adv4;
    assign adv2         = !r2_valid || adv3;
    assign adv1         = !r1_valid || adv2;
    assign adv_b        = !r_b_valid || adv1;
    assign o_snap_ready = adv_b;

    // Leaf sums and the default candidate's counts.
    always_comb begin
        for (int i = 0; i < NUM_THR; i++) begin
            w_leaf[i].total   = SUM_W'(r_b_clr[i]) + SUM_W'(r_b_set[i]);
            w_leaf[i].idx     = IDX_W'(i);
            w_leaf[i].clr_cnt = r_b_clr[i];
            w_leaf[i].set_cnt = r_b_set[i];
        end
        w_def.clr_cnt = r_b_clr[IDX_DEFAULT];
        w_def.set_cnt = r_b_set[IDX_DEFAULT];
    end

    // Pairwise minimum, lower index wins a tie; an odd entry passes through.
    always_comb begin
        for (int j = 0; j < L1; j++) begin
            if (2 * j + 1 < NUM_THR) begin
                n1[j] = pick(w_leaf[2*j], w_leaf[2*j+1]);
            end else begin
                n1[j] = w_leaf[2*j];
            end
        end
        for (int j = 0; j < L2; j++) begin
            if (2 * j + 1 < L1) begin
                n2[j] = pick(r1[2*j], r1[2*j+1]);
            end else begin
                n2[j] = r1[2*j];
            end
        end
        for (int j = 0; j < L3; j++) begin
            if (2 * j + 1 < L2) begin
                n3[j] = pick(r2[2*j], r2[2*j+1]);
            end else begin
                n3[j] = r2[2*j];
            end
        end
        n4 = pick(r3[0], r3[L3-1]);
    end

    // The minimum counts only if it is under the bound and under the default sum.
    assign w_def_total = SUM_W'(r4_def.clr_cnt) + SUM_W'(r4_def.set_cnt);
    assign w_found     = BOUND_W'(r4.total) < i_bound;
    assign w_take      = w_found && (r4.total < w_def_total);

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv_b) begin
                r_b_valid <= i_snap_valid;
            end
            if (adv1) begin
                r1_valid <= r_b_valid;
            end
            if (adv2) begin
                r2_valid <= r1_valid;
            end
            if (adv3) begin
                r3_valid <= r2_valid;
            end
            if (adv4) begin
                r4_valid <= r3_valid;
            end
            if (adv_o) begin
                r_o_valid <= r4_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b_clr <= i_snap_clr;
            r_b_set <= i_snap_set;
        end
        if (adv1) begin
            r1     <= n1;
            r1_def <= w_def;
        end
        if (adv2) begin
            r2     <= n2;
            r2_def <= r1_def;
        end
        if (adv3) begin
            r3     <= n3;
            r3_def <= r2_def;
        end
        if (adv4) begin
            r4     <= n4;
            r4_def <= r3_def;
        end
        if (adv_o) begin
            if (w_take) begin
                r_o_thr  <= thr_of(r4.idx);
                r_o_clr  <= r4.clr_cnt;
                r_o_set  <= r4.set_cnt;
                r_o_dflt <= 1'b0;
            end else begin
                r_o_thr  <= THR_DEFAULT;
                r_o_clr  <= r4_def.clr_cnt;
                r_o_set  <= r4_def.set_cnt;
                r_o_dflt <= 1'b1;
            end
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_chosen_threshold = r_o_thr;
    assign o_clear_groups     = r_o_clr;
    assign o_set_groups       = r_o_set;
    assign o_used_default     = r_o_dflt;

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bwts_pkg::*;

    localparam int STALL_LIMIT      = 3000;
    localparam int HOLD_CYCLES      = 300;
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PIXELS    = 120;
    localparam int RANDOM_IMAGES    = 6;
    localparam int BURST_IMAGES     = 40;
    localparam int DIM_MAX          = (1 << DIM_W) - 1;
    localparam int CFG_IDX_MAX      = (1 << CFG_IDX_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = REG_HEIGHT + 1'b1;

    typedef struct packed {
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
        logic             group_end;
        logic             image_end;
    } pixel_t;

    typedef struct packed {
        logic [THR_W-1:0] chosen;
        logic [CNT_W-1:0] clear_groups;
        logic [CNT_W-1:0] set_groups;
        logic             used_default;
    } verdict_t;

    typedef enum {ROW_PIXEL, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        pixel_t               px;
        bit                   known;
        verdict_t             want;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]     reg_data;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [RGB_W-1:0]     red = '0;
    logic [RGB_W-1:0]     green = '0;
    logic [RGB_W-1:0]     blue = '0;
    logic                 group_end = 1'b0;
    logic                 image_end = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [THR_W-1:0]     chosen_threshold;
    logic [CNT_W-1:0]     clear_groups;
    logic [CNT_W-1:0]     set_groups;
    logic                 used_default;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    // Predictor state: per-threshold group flags and uniform-group tallies.
    logic [1:0]  grp_flags [NUM_THR];
    int unsigned clr_tally [NUM_THR];
    int unsigned set_tally [NUM_THR];
    int unsigned dim_w = 1;
    int unsigned dim_h = 1;

    verdict_t expected_picks[$];
    verdict_t head;

    int errors = 0;
    int pixels_sent = 0;
    int images_sent = 0;
    int results_seen = 0;
    int other_picks = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_count = 0;

    bw_threshold_selector_core u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_red              (red),
        .i_green            (green),
        .i_blue             (blue),
        .i_group_end        (group_end),
        .i_image_end        (image_end),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_chosen_threshold (chosen_threshold),
        .o_clear_groups     (clear_groups),
        .o_set_groups       (set_groups),
        .o_used_default     (used_default),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Reset all per-threshold tallies, as the block does after each image.
    function automatic void clear_tallies();
        for (int i = 0; i < NUM_THR; i++) begin
            grp_flags[i] = FLAG_CLEAR | FLAG_SET;
            clr_tally[i] = 0;
            set_tally[i] = 0;
        end
    endfunction

    initial clear_tallies();

    // Update the tallies for one accepted pixel; at image end, work out the pick.
    task automatic tally_pixel(input pixel_t p, output bit done, output verdict_t v);
        int unsigned total;
        int unsigned level;
        int unsigned best;
        int unsigned dflt_sum;
        int          best_idx;
        bit          found;
        total = p.red + p.green + p.blue;
        for (int i = 0; i < NUM_THR; i++) begin
            level = 3 * (THR_FIRST + THR_STEP * i);
            if (total >= level) begin
                grp_flags[i] &= ~FLAG_CLEAR;
            end else begin
                grp_flags[i] &= ~FLAG_SET;
            end
            if (p.group_end || p.image_end) begin
                if (grp_flags[i] & FLAG_CLEAR) begin
                    if (clr_tally[i] < CNT_LIMIT) clr_tally[i]++;
                end else if (grp_flags[i] & FLAG_SET) begin
                    if (set_tally[i] < CNT_LIMIT) set_tally[i]++;
                end
                grp_flags[i] = FLAG_CLEAR | FLAG_SET;
            end
        end
        done = p.image_end;
        v = '0;
        if (done) begin
            // Scan candidates in rising order against the bound from the geometry.
            best = 2 * ((dim_w * dim_h) / 8);
            best_idx = IDX_DEFAULT;
            found = 1'b0;
            for (int i = 0; i < NUM_THR; i++) begin
                if (clr_tally[i] + set_tally[i] < best) begin
                    best = clr_tally[i] + set_tally[i];
                    best_idx = i;
                    found = 1'b1;
                end
            end
            dflt_sum = clr_tally[IDX_DEFAULT] + set_tally[IDX_DEFAULT];
            if (found && best < dflt_sum) begin
                v.chosen = THR_W'(THR_FIRST + THR_STEP * best_idx);
                v.clear_groups = CNT_W'(clr_tally[best_idx]);
                v.set_groups = CNT_W'(set_tally[best_idx]);
                v.used_default = 1'b0;
            end else begin
                v.chosen = THR_DEFAULT;
                v.clear_groups = CNT_W'(clr_tally[IDX_DEFAULT]);
                v.set_groups = CNT_W'(set_tally[IDX_DEFAULT]);
                v.used_default = 1'b1;
            end
            clear_tallies();
        end
    endtask

    // Offer one pixel after a random gap and record what it should produce.
    task automatic send_pixel(input pixel_t p, input bit known, input verdict_t known_v);
        verdict_t v;
        bit       done;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        red <= p.red;
        green <= p.green;
        blue <= p.blue;
        group_end <= p.group_end;
        image_end <= p.image_end;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
        tally_pixel(p, done, v);
        if (done) begin
            expected_picks.push_back(known ? known_v : v);
            images_sent++;
        end
    endtask

    // Let every pending pick come out, then give the pipeline time to empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register transaction; the caller lowers the valid when done.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_WIDTH) begin
            dim_w = data;
        end else if (idx == REG_HEIGHT) begin
            dim_h = data;
        end
    endtask

    task automatic set_geometry(input int w, input int h);
        drain();
        reg_write(REG_WIDTH, DIM_W'(w));
        reg_write(REG_HEIGHT, DIM_W'(h));
        // Now and then a write to an index that does not exist.
        if ($urandom_range(3) == 0) begin
            reg_write(CFG_IDX_W'($urandom_range(CFG_IDX_MAX, REG_UNUSED)), DIM_W'($urandom));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [RGB_W-1:0] shade(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return RGB_W'(v);
    endfunction

    // A raster image of groups of eight, each group around its own gray level.
    // A broken image has a random length and random group boundaries.
    task automatic send_image(input int w, input int h, input bit broken);
        pixel_t p;
        int     n;
        int     center;
        int     spread;
        n = broken ? int'($urandom_range(w * h, 1)) : w * h;
        center = 0;
        spread = 0;
        for (int k = 0; k < n; k++) begin
            if (k % 8 == 0 || (broken && $urandom_range(3) == 0)) begin
                center = $urandom_range(255);
                case ($urandom_range(3))
                    0: spread = 0;
                    1: spread = 6;
                    2: spread = 30;
                    default: spread = 128;
                endcase
            end
            p.red = shade(center, spread);
            p.green = shade(center, spread);
            p.blue = shade(center, spread);
            p.group_end = broken ? ($urandom_range(3) == 0) : (k % 8 == 7);
            p.image_end = (k == n - 1);
            send_pixel(p, 1'b0, '0);
        end
    endtask

    function automatic row_t plain_row(input int r, input int g, input int b,
                                       input bit ge, input bit ie);
        row_t row;
        row.kind = ROW_PIXEL;
        row.px = '{RGB_W'(r), RGB_W'(g), RGB_W'(b), ge, ie};
        row.known = 1'b0;
        row.want = '0;
        row.reg_idx = '0;
        row.reg_data = '0;
        return row;
    endfunction

    // A pixel ending an image whose pick can only be the default threshold.
    function automatic row_t default_row(input int r, input int g, input int b,
                                         input bit ge, input int clr, input int st);
        row_t row;
        row = plain_row(r, g, b, ge, 1'b1);
        row.known = 1'b1;
        row.want = '{THR_DEFAULT, CNT_W'(clr), CNT_W'(st), 1'b1};
        return row;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        row_t row;
        row = plain_row(0, 0, 0, 1'b0, 1'b0);
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = DIM_W'(data);
        return row;
    endfunction

    // Result receiver: random stalls, plus a long hold-off on request.
    initial begin
        int seen;
        seen = 0;
        forever begin
            @(posedge clk);
            if (hold_count != seen) begin
                seen = hold_count;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare every result transaction with the oldest pending pick.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (used_default !== 1'b1) other_picks++;
            if (expected_picks.size() == 0) begin
                $display("%0t: result with nothing pending, expected none got threshold %0d",
                         $time, chosen_threshold);
                errors++;
            end else begin
                head = expected_picks.pop_front();
                check_field("chosen_threshold", head.chosen, chosen_threshold);
                check_field("clear_groups", head.clear_groups, clear_groups);
                check_field("set_groups", head.set_groups, set_groups);
                check_field("used_default", head.used_default, used_default);
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on any channel.
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin
        row_t   plan[$];
        pixel_t p;
        int     w;
        int     h;
        int     cw;
        int     ch;
        int     base_pixels;
        int     base_images;

        wait (rst_n === 1'b1);
        @(posedge clk);
        tx_idle_pct = 14;
        rx_idle_pct = 59;

        // Directed part. After reset the bound is zero, so only 128 can come out.
        plan.push_back(default_row(0, 0, 0, 1'b0, 1, 0));
        plan.push_back(default_row(255, 255, 255, 1'b0, 0, 1));
        plan.push_back(default_row(255, 0, 0, 1'b1, 1, 0));
        // Two groups that leave 112 as the only threshold with no uniform group;
        // the image ends without a group end on the last pixel.
        plan.push_back(reg_row(REG_WIDTH, 64));
        plan.push_back(reg_row(REG_HEIGHT, 1));
        plan.push_back(plain_row(50, 50, 50, 1'b0, 1'b0));
        plan.push_back(plain_row(200, 200, 200, 1'b1, 1'b0));
        plan.push_back(plain_row(100, 100, 100, 1'b0, 1'b0));
        plan.push_back(plain_row(120, 120, 120, 1'b0, 1'b1));
        // A write to an unknown index must leave the width alone.
        plan.push_back(reg_row(REG_UNUSED, 0));
        plan.push_back(plain_row(50, 50, 50, 1'b0, 1'b0));
        plan.push_back(plain_row(200, 200, 200, 1'b1, 1'b0));
        plan.push_back(plain_row(100, 100, 100, 1'b0, 1'b0));
        plan.push_back(plain_row(120, 120, 120, 1'b0, 1'b1));
        // Zero width gives a zero bound.
        plan.push_back(reg_row(REG_WIDTH, 0));
        plan.push_back(default_row(10, 10, 10, 1'b0, 1, 0));
        // Largest geometry; sums exactly at and just below the level for 128.
        plan.push_back(reg_row(REG_WIDTH, DIM_MAX));
        plan.push_back(reg_row(REG_HEIGHT, DIM_MAX));
        plan.push_back(default_row(128, 128, 128, 1'b1, 0, 1));
        plan.push_back(default_row(128, 128, 127, 1'b1, 1, 0));
        // Zero height gives a zero bound as well.
        plan.push_back(reg_row(REG_HEIGHT, 0));
        plan.push_back(default_row(255, 255, 255, 1'b0, 0, 1));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                drain();
                reg_write(plan[i].reg_idx, plan[i].reg_data);
                cfg_valid <= 1'b0;
            end else begin
                send_pixel(plan[i].px, plan[i].known, plan[i].want);
            end
        end

        // Random images in three idling modes.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 59;
                end
                1: begin
                    tx_idle_pct = 59;
                    rx_idle_pct = 14;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            base_pixels = pixels_sent;
            base_images = images_sent;
            while (pixels_sent - base_pixels < RANDOM_PIXELS ||
                   images_sent - base_images < RANDOM_IMAGES) begin
                w = 8 * $urandom_range(2, 1);
                h = $urandom_range(3, 1);
                cw = w;
                ch = h;
                case ($urandom_range(7))
                    0: cw = 0;
                    1: ch = DIM_MAX;
                    2: cw = $urandom_range(DIM_MAX);
                    3: ch = $urandom_range(DIM_MAX);
                    default: ;
                endcase
                set_geometry(cw, ch);
                repeat ($urandom_range(4, 2)) send_image(w, h, $urandom_range(99) < 20);
            end
        end

        // Hold the results back while one-pixel images keep coming, so the
        // block fills up and stalls its input.
        drain();
        hold_count <= hold_count + 1;
        for (int k = 0; k < BURST_IMAGES; k++) begin
            p = '{RGB_W'($urandom), RGB_W'($urandom), RGB_W'($urandom), 1'($urandom), 1'b1};
            send_pixel(p, 1'b0, '0);
        end

        drain();
        $display("Sent %0d pixels in %0d images under three idling modes and a long stall.",
                 pixels_sent, images_sent);
        $display("Checked %0d results; %0d of them picked a threshold other than the default.",
                 results_seen, other_picks);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
